// File: rtl/fat12_pkg.sv
// fat12_pkg: shared constants and types for the FAT12 cluster chain writer.
// No dependencies.
`default_nettype none
package fat12_pkg;
  localparam int TableEntries = 4096;
  localparam int SectorBytes  = 512;
  localparam logic [11:0] EndMark    = 12'hFFF;
  localparam logic [12:0] SectorBase = 13'd31;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_FULL  = 2'd3
  } kind_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [11:0] idx;
    logic [11:0] val;
    logic [7:0]  dbyte;
    logic        last;
  } item_t;
endpackage
`default_nettype wire

// File: rtl/fat12_cluster_chain_writer.sv
// fat12_cluster_chain_writer: top level, front queue plus back engine.
// Depends on fat12_pkg, fat12_front, fat12_back, fat12_ram.
//  channel | dir | handshake              | payload
//  input   | in  | in_valid / in_ready    | command, entry_index, entry_value, data_byte, last_byte
//  result  | out | out_valid / out_ready  | kind, sector, byte_offset, write_byte, read_value,
//          |     |                        | start_sector, last_result
// An accepted item is registered in the front queue before the back end sees it. Back end:
// a byte inside a sector passes S_EMIT and S_OUT, a last byte then also S_DONE and S_OUT;
// a read passes S_READ, S_READ_W and S_OUT; a load is written in S_IDLE. Claiming a cluster
// adds S_SCAN and S_SCAN_W per table entry scanned plus S_CLAIM, and S_LINK when linking.
// A result waits in S_OUT for out_ready. After reset the table is cleared; no item runs then.
// A two-entry queue decouples input acceptance from result stalls.
`default_nettype none
module fat12_cluster_chain_writer #(
  parameter int TABLE_ENTRIES = fat12_pkg::TableEntries,
  parameter int SECTOR_BYTES  = fat12_pkg::SectorBytes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [11:0] entry_index,
  input  wire logic [11:0] entry_value,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [12:0]      sector,
  output logic [8:0]       byte_offset,
  output logic [7:0]       write_byte,
  output logic [11:0]      read_value,
  output logic [12:0]      start_sector,
  output logic             last_result
);
  logic q_valid, q_ready;
  fat12_pkg::item_t q_item;

  fat12_front #(.TableEntries(TABLE_ENTRIES)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .cmd_in(command), .idx_in(entry_index), .val_in(entry_value),
    .dbyte_in(data_byte), .last_in(last_byte),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  fat12_back #(.TableEntries(TABLE_ENTRIES), .SectorBytes(SECTOR_BYTES)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .sector(sector),
    .byte_offset(byte_offset), .write_byte(write_byte), .read_value(read_value),
    .start_sector(start_sector), .last_result(last_result)
  );
endmodule
`default_nettype wire

// File: rtl/fat12_ram.sv
// fat12_ram: generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module fat12_ram #(
  parameter int Width = 12,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: rtl/fat12_front.sv
// fat12_front: input acceptance, classification and a two-entry item queue.
// Depends on fat12_pkg.
`default_nettype none
module fat12_front #(
  parameter int TableEntries = fat12_pkg::TableEntries
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       cmd_in,
  input  wire logic [11:0]      idx_in,
  input  wire logic [11:0]      val_in,
  input  wire logic [7:0]       dbyte_in,
  input  wire logic             last_in,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output fat12_pkg::item_t      q_item
);
  fat12_pkg::item_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  fat12_pkg::item_t cls;
  logic push, pop, keep;

  always_comb begin
    cls.cmd   = fat12_pkg::cmd_t'(cmd_in);
    cls.idx   = idx_in;
    cls.val   = val_in;
    cls.dbyte = dbyte_in;
    cls.last  = last_in;
    // out-of-range index: a load is dropped, a read answers zero
    keep = (cmd_in != fat12_pkg::CMD_NONE);
    if ({20'd0, idx_in} >= 32'(TableEntries)) begin
      if (cmd_in == fat12_pkg::CMD_LOAD) keep = 1'b0;
    end
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = q[rd_ptr];
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: rtl/fat12_back.sv
// fat12_back: table clear, free-entry scan, chain update and result output.
// Depends on fat12_pkg and fat12_ram.
`default_nettype none
module fat12_back #(
  parameter int TableEntries = fat12_pkg::TableEntries,
  parameter int SectorBytes  = fat12_pkg::SectorBytes
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire fat12_pkg::item_t q_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            kind,
  output logic [12:0]           sector,
  output logic [8:0]            byte_offset,
  output logic [7:0]            write_byte,
  output logic [11:0]           read_value,
  output logic [12:0]           start_sector,
  output logic                  last_result
);
  localparam int AW = $clog2(TableEntries);
  localparam int FW = $clog2(SectorBytes + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_READ_W, S_SCAN, S_SCAN_W, S_CLAIM, S_LINK,
    S_EMIT, S_DONE, S_OUT
  } state_t;

  state_t state, ret;
  logic [AW:0] clr;
  logic [AW-1:0] scan, ram_addr;
  logic ram_we;
  logic [11:0] ram_wdata, ram_rdata;
  logic [11:0] cur, first, found;
  logic [FW-1:0] fill;
  logic open, full;
  fat12_pkg::item_t it;

  fat12_ram #(.Width(12), .Depth(TableEntries)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_comb begin
    ram_we = 1'b0;
    ram_addr = scan;
    ram_wdata = 12'd0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr[AW-1:0];
      end
      S_IDLE: begin
        ram_addr = q_item.idx[AW-1:0];
        ram_we = q_valid && q_item.cmd == fat12_pkg::CMD_LOAD;
        ram_wdata = q_item.val;
      end
      S_READ, S_READ_W: ram_addr = it.idx[AW-1:0];
      S_CLAIM: begin
        ram_we = 1'b1;
        ram_addr = found[AW-1:0];
        ram_wdata = fat12_pkg::EndMark;
      end
      S_LINK: begin
        ram_we = 1'b1;
        ram_addr = cur[AW-1:0];
        ram_wdata = found;
      end
      S_DONE: begin
        ram_we = 1'b1;
        ram_addr = cur[AW-1:0];
        ram_wdata = fat12_pkg::EndMark;
      end
      default: ;
    endcase
  end

  assign q_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ret <= S_IDLE;
      clr <= '0;
      scan <= '0;
      cur <= '0;
      first <= '0;
      found <= '0;
      fill <= '0;
      open <= 1'b0;
      full <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(TableEntries - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          it <= q_item;
          unique case (q_item.cmd)
            fat12_pkg::CMD_READ: state <= S_READ;
            fat12_pkg::CMD_BYTE: begin
              if (!open) begin
                open <= 1'b1;
                full <= 1'b0;
                fill <= '0;
                scan <= AW'(2);
                state <= S_SCAN;
              end else if (full) begin
                if (q_item.last) begin
                  open <= 1'b0;
                  full <= 1'b0;
                  kind <= fat12_pkg::KIND_FULL;
                  sector <= '0; byte_offset <= '0; write_byte <= '0;
                  read_value <= '0; start_sector <= '0; last_result <= 1'b1;
                  out_valid <= 1'b1;
                  state <= S_OUT;
                  ret <= S_IDLE;
                end
              end else if (fill >= FW'(SectorBytes)) begin
                scan <= AW'(2);
                state <= S_SCAN;
              end else state <= S_EMIT;
            end
            default: ;
          endcase
        end
        S_READ: state <= S_READ_W;
        S_READ_W: begin
          kind <= fat12_pkg::KIND_READ;
          sector <= '0; byte_offset <= '0; write_byte <= '0; start_sector <= '0;
          read_value <= ({20'd0, it.idx} >= 32'(TableEntries)) ? 12'd0 : ram_rdata;
          last_result <= 1'b1;
          out_valid <= 1'b1;
          ret <= S_IDLE;
          state <= S_OUT;
        end
        S_SCAN: state <= S_SCAN_W;
        S_SCAN_W: begin
          if (ram_rdata == 12'd0) begin
            found <= 12'(scan);
            state <= S_CLAIM;
          end else if (scan == AW'(TableEntries - 1)) begin
            // no free entry
            full <= 1'b1;
            if (it.last) begin
              open <= 1'b0;
              full <= 1'b0;
            end
            if (fill == '0) begin
              first <= '0;
              cur <= '0;
            end
            kind <= fat12_pkg::KIND_FULL;
            sector <= '0; byte_offset <= '0; write_byte <= '0;
            read_value <= '0; start_sector <= '0; last_result <= 1'b1;
            out_valid <= 1'b1;
            ret <= S_IDLE;
            state <= S_OUT;
          end else begin
            scan <= scan + 1'b1;
            state <= S_SCAN;
          end
        end
        S_CLAIM: begin
          if (fill == '0) begin
            first <= found;
            cur <= found;
            state <= S_EMIT;
          end else state <= S_LINK;
        end
        S_LINK: begin
          cur <= found;
          fill <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          kind <= fat12_pkg::KIND_WRITE;
          sector <= {1'b0, cur} + fat12_pkg::SectorBase;
          byte_offset <= 9'(fill);
          write_byte <= it.dbyte;
          read_value <= '0; start_sector <= '0;
          last_result <= ~it.last;
          fill <= fill + 1'b1;
          out_valid <= 1'b1;
          ret <= it.last ? S_DONE : S_IDLE;
          state <= S_OUT;
        end
        S_DONE: begin
          open <= 1'b0;
          full <= 1'b0;
          kind <= fat12_pkg::KIND_DONE;
          sector <= '0; byte_offset <= '0; write_byte <= '0; read_value <= '0;
          start_sector <= {1'b0, first} + fat12_pkg::SectorBase;
          last_result <= 1'b1;
          out_valid <= 1'b1;
          ret <= S_IDLE;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= ret;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
